@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file soi_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define ASSERT_CLK_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// clocked assertion, checked during reset as well
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

@@ sv/soi_pkg.sv @@
// ----------------------------------------------------------------------------
// soi_pkg
// shared constants and types of the segment orientation / intersection block
// ----------------------------------------------------------------------------
package soi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int MARGIN_W        = 16;
    localparam int FUNC_W          = 2;
    localparam int OUT_W           = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLL_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_MARGIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TCH_MARGIN = 2'd3;

    localparam logic [CFG_DATA_W-1:0] ORIENT_TOL_RST = 32'd0;
    localparam logic [CFG_DATA_W-1:0] COLL_TOL_RST   = 32'd1000;
    localparam logic [MARGIN_W-1:0]   EXT_MARGIN_RST = 16'd0;
    localparam logic [MARGIN_W-1:0]   TCH_MARGIN_RST = 16'd0;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_ORIENT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ON_SEG    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INTERSECT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CROSS     = 2'd3;

    // orientation codes, two bit signed
    localparam logic [1:0] SIDE_ZERO  = 2'b00;
    localparam logic [1:0] SIDE_LEFT  = 2'b01;
    localparam logic [1:0] SIDE_RIGHT = 2'b11;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic s4_en;
    } pipe_ctl_t;

endpackage

@@ sv/soi_cross.sv @@
// ----------------------------------------------------------------------------
// soi_cross
// four stage lane: differences, products, cross product, tolerance classify
// ----------------------------------------------------------------------------
module soi_cross import soi_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  pipe_ctl_t              ctl,
    input  logic signed [CW-1:0]   pa_lon,
    input  logic signed [CW-2:0]   pa_lat,
    input  logic signed [CW-1:0]   pb_lon,
    input  logic signed [CW-2:0]   pb_lat,
    input  logic signed [CW-1:0]   pc_lon,
    input  logic signed [CW-2:0]   pc_lat,
    input  logic [CFG_DATA_W-1:0]  orient_tol,
    input  logic [CFG_DATA_W-1:0]  coll_tol,
    output logic [1:0]             side,
    output logic                   near
);
    localparam int LON_DW = CW + 1;
    localparam int LAT_DW = CW;
    localparam int PW     = LON_DW + LAT_DW;
    localparam int XW     = PW + 1;

    logic signed [LON_DW-1:0] dx_ab_reg, dx_ac_reg, dx_ab_next, dx_ac_next;
    logic signed [LAT_DW-1:0] dy_ab_reg, dy_ac_reg, dy_ab_next, dy_ac_next;
    logic signed [PW-1:0]     dx_ab_w, dx_ac_w, dy_ab_w, dy_ac_w;
    logic signed [PW-1:0]     p1_reg, p2_reg;
    logic signed [XW-1:0]     cross_reg, cross_next;
    logic signed [XW-1:0]     otol_x, ctol_x;
    logic [1:0]               side_reg, side_next;
    logic                     near_reg, near_next;

    assign dx_ab_next = $signed({pb_lon[CW-1], pb_lon}) - $signed({pa_lon[CW-1], pa_lon});
    assign dx_ac_next = $signed({pc_lon[CW-1], pc_lon}) - $signed({pa_lon[CW-1], pa_lon});
    assign dy_ab_next = $signed({pb_lat[CW-2], pb_lat}) - $signed({pa_lat[CW-2], pa_lat});
    assign dy_ac_next = $signed({pc_lat[CW-2], pc_lat}) - $signed({pa_lat[CW-2], pa_lat});

    assign dx_ab_w = $signed({{(PW-LON_DW){dx_ab_reg[LON_DW-1]}}, dx_ab_reg});
    assign dx_ac_w = $signed({{(PW-LON_DW){dx_ac_reg[LON_DW-1]}}, dx_ac_reg});
    assign dy_ab_w = $signed({{(PW-LAT_DW){dy_ab_reg[LAT_DW-1]}}, dy_ab_reg});
    assign dy_ac_w = $signed({{(PW-LAT_DW){dy_ac_reg[LAT_DW-1]}}, dy_ac_reg});

    assign cross_next = $signed({p1_reg[PW-1], p1_reg}) - $signed({p2_reg[PW-1], p2_reg});

    assign otol_x = $signed({{(XW-CFG_DATA_W){1'b0}}, orient_tol});
    assign ctol_x = $signed({{(XW-CFG_DATA_W){1'b0}}, coll_tol});

    always_comb begin
        if (cross_reg > otol_x) begin
            side_next = SIDE_LEFT;
        end else if (cross_reg < -otol_x) begin
            side_next = SIDE_RIGHT;
        end else begin
            side_next = SIDE_ZERO;
        end
        near_next = !(cross_reg > ctol_x) && !(cross_reg < -ctol_x);
    end

    always_ff @(posedge aclk) begin
        if (ctl.s1_en) begin
            dx_ab_reg <= dx_ab_next;
            dx_ac_reg <= dx_ac_next;
            dy_ab_reg <= dy_ab_next;
            dy_ac_reg <= dy_ac_next;
        end
        if (ctl.s2_en) begin
            p1_reg <= dx_ab_w * dy_ac_w;
            p2_reg <= dy_ab_w * dx_ac_w;
        end
        if (ctl.s3_en) begin
            cross_reg <= cross_next;
        end
        if (ctl.s4_en) begin
            side_reg <= side_next;
            near_reg <= near_next;
        end
    end

    assign side = side_reg;
    assign near = near_reg;

endmodule

@@ sv/soi_box.sv @@
// ----------------------------------------------------------------------------
// soi_box
// widened bounding box test of one point against one segment, four stages
// ----------------------------------------------------------------------------
module soi_box import soi_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic                  aclk,
    input  pipe_ctl_t             ctl,
    input  logic signed [CW-1:0]  pa_lon,
    input  logic signed [CW-2:0]  pa_lat,
    input  logic signed [CW-1:0]  pb_lon,
    input  logic signed [CW-2:0]  pb_lat,
    input  logic signed [CW-1:0]  pp_lon,
    input  logic signed [CW-2:0]  pp_lat,
    input  logic [MARGIN_W-1:0]   margin,
    output logic                  hit
);
    localparam int BW = CW + 2;

    logic signed [BW-1:0] a_lon_x, b_lon_x, a_lat_x, b_lat_x, m_x;
    logic signed [BW-1:0] lo_lon_next, hi_lon_next, lo_lat_next, hi_lat_next;
    logic signed [BW-1:0] lo_lon_reg, hi_lon_reg, lo_lat_reg, hi_lat_reg;
    logic signed [CW-1:0] pp_lon_reg;
    logic signed [CW-2:0] pp_lat_reg;
    logic signed [BW-1:0] p_lon_x, p_lat_x;
    logic                 hit2_reg, hit3_reg, hit4_reg, hit_next;

    assign a_lon_x = $signed({{2{pa_lon[CW-1]}}, pa_lon});
    assign b_lon_x = $signed({{2{pb_lon[CW-1]}}, pb_lon});
    assign a_lat_x = $signed({{3{pa_lat[CW-2]}}, pa_lat});
    assign b_lat_x = $signed({{3{pb_lat[CW-2]}}, pb_lat});
    assign m_x     = $signed({{(BW-MARGIN_W){1'b0}}, margin});

    always_comb begin
        if (a_lon_x < b_lon_x) begin
            lo_lon_next = a_lon_x - m_x;
            hi_lon_next = b_lon_x + m_x;
        end else begin
            lo_lon_next = b_lon_x - m_x;
            hi_lon_next = a_lon_x + m_x;
        end
        if (a_lat_x < b_lat_x) begin
            lo_lat_next = a_lat_x - m_x;
            hi_lat_next = b_lat_x + m_x;
        end else begin
            lo_lat_next = b_lat_x - m_x;
            hi_lat_next = a_lat_x + m_x;
        end
    end

    assign p_lon_x  = $signed({{2{pp_lon_reg[CW-1]}}, pp_lon_reg});
    assign p_lat_x  = $signed({{3{pp_lat_reg[CW-2]}}, pp_lat_reg});
    assign hit_next = (lo_lon_reg <= p_lon_x) && (p_lon_x <= hi_lon_reg) &&
                      (lo_lat_reg <= p_lat_x) && (p_lat_x <= hi_lat_reg);

    always_ff @(posedge aclk) begin
        if (ctl.s1_en) begin
            lo_lon_reg <= lo_lon_next;
            hi_lon_reg <= hi_lon_next;
            lo_lat_reg <= lo_lat_next;
            hi_lat_reg <= hi_lat_next;
            pp_lon_reg <= pp_lon;
            pp_lat_reg <= pp_lat;
        end
        if (ctl.s2_en) begin
            hit2_reg <= hit_next;
        end
        if (ctl.s3_en) begin
            hit3_reg <= hit2_reg;
        end
        if (ctl.s4_en) begin
            hit4_reg <= hit3_reg;
        end
    end

    assign hit = hit4_reg;

endmodule

@@ sv/segment_orientation_intersect.sv @@
// ----------------------------------------------------------------------------
// segment_orientation_intersect
// orientation, point on segment, intersect and proper crossing predicates
// ----------------------------------------------------------------------------
// input stream: one word per query, four points in s_tdata and the function
// code in s_tuser. result stream: one word per query, verdict and the signed
// side of point c against line ab.
// configuration: cfg_wr_en, cfg_index, cfg_wdata write one register per
// cycle; write them only while no query is in flight.
// path: an accepted word moves through the difference, product, cross product
// and classify registers of each lane, then the result register, which drives
// m_tvalid. throughput: one word per cycle while m_tready is high; the path
// through the stage that forms the two coordinate products of each cross lane
// sets the clock. reset: aresetn low empties all stages and restores register
// defaults. stall: with m_tready low, stages still fill their empty slots, so up
// to five words are held before s_tready drops; nothing is lost or repeated.
module segment_orientation_intersect import soi_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_RAW = 8 * COORD_WIDTH - 4,
    localparam int IN_W   = ((IN_RAW + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // a_lon, a_lat, b_lon, b_lat, c_lon, c_lat, d_lon, d_lat, zero pad
    input  logic [IN_W-1:0]       s_tdata,
    // func
    input  logic [FUNC_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // verdict, side, zero pad
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);
    localparam int CW   = COORD_WIDTH;
    localparam int PT_W = 2 * CW - 1;
    localparam int NSTG = 5;

    logic signed [CW-1:0] pt_lon [4];
    logic signed [CW-2:0] pt_lat [4];

    logic [CFG_DATA_W-1:0] otol_reg, ctol_reg;
    logic [MARGIN_W-1:0]   emarg_reg, tmarg_reg;

    logic [NSTG-1:0]   vld_reg;
    logic [NSTG-1:0]   rdy;
    pipe_ctl_t         ctl;
    logic [FUNC_W-1:0] func1_reg, func2_reg, func3_reg, func4_reg;

    logic [1:0] o1, o2, o3, o4;
    logic       near1, hit_ext, hit_c, hit_d, hit_a, hit_b;
    logic       verdict_next, differ, touch;
    logic [2:0] res_reg;

    for (genvar i = 0; i < 4; i++) begin : g_unpack
        assign pt_lon[i] = s_tdata[i*PT_W +: CW];
        assign pt_lat[i] = s_tdata[i*PT_W + CW +: CW-1];
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            otol_reg  <= ORIENT_TOL_RST;
            ctol_reg  <= COLL_TOL_RST;
            emarg_reg <= EXT_MARGIN_RST;
            tmarg_reg <= TCH_MARGIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ORIENT_TOL: otol_reg  <= cfg_wdata;
                REG_COLL_TOL:   ctol_reg  <= cfg_wdata;
                REG_EXT_MARGIN: emarg_reg <= cfg_wdata[MARGIN_W-1:0];
                REG_TCH_MARGIN: tmarg_reg <= cfg_wdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake, a stage loads when empty or when its successor loads
    always_comb begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign ctl.s1_en = rdy[0];
    assign ctl.s2_en = rdy[1];
    assign ctl.s3_en = rdy[2];
    assign ctl.s4_en = rdy[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.s1_en) begin
            func1_reg <= s_tuser;
        end
        if (ctl.s2_en) begin
            func2_reg <= func1_reg;
        end
        if (ctl.s3_en) begin
            func3_reg <= func2_reg;
        end
        if (ctl.s4_en) begin
            func4_reg <= func3_reg;
        end
    end

    // cross product lanes: abc, abd, cda, cdb
    soi_cross #(.CW(CW)) u_cross_abc (
        .aclk(aclk), .ctl(ctl),
        .pa_lon(pt_lon[0]), .pa_lat(pt_lat[0]),
        .pb_lon(pt_lon[1]), .pb_lat(pt_lat[1]),
        .pc_lon(pt_lon[2]), .pc_lat(pt_lat[2]),
        .orient_tol(otol_reg), .coll_tol(ctol_reg),
        .side(o1), .near(near1)
    );

    soi_cross #(.CW(CW)) u_cross_abd (
        .aclk(aclk), .ctl(ctl),
        .pa_lon(pt_lon[0]), .pa_lat(pt_lat[0]),
        .pb_lon(pt_lon[1]), .pb_lat(pt_lat[1]),
        .pc_lon(pt_lon[3]), .pc_lat(pt_lat[3]),
        .orient_tol(otol_reg), .coll_tol(ctol_reg),
        .side(o2), .near()
    );

    soi_cross #(.CW(CW)) u_cross_cda (
        .aclk(aclk), .ctl(ctl),
        .pa_lon(pt_lon[2]), .pa_lat(pt_lat[2]),
        .pb_lon(pt_lon[3]), .pb_lat(pt_lat[3]),
        .pc_lon(pt_lon[0]), .pc_lat(pt_lat[0]),
        .orient_tol(otol_reg), .coll_tol(ctol_reg),
        .side(o3), .near()
    );

    soi_cross #(.CW(CW)) u_cross_cdb (
        .aclk(aclk), .ctl(ctl),
        .pa_lon(pt_lon[2]), .pa_lat(pt_lat[2]),
        .pb_lon(pt_lon[3]), .pb_lat(pt_lat[3]),
        .pc_lon(pt_lon[1]), .pc_lat(pt_lat[1]),
        .orient_tol(otol_reg), .coll_tol(ctol_reg),
        .side(o4), .near()
    );

    // box tests
    soi_box #(.CW(CW)) u_box_ext (
        .aclk(aclk), .ctl(ctl),
        .pa_lon(pt_lon[0]), .pa_lat(pt_lat[0]),
        .pb_lon(pt_lon[1]), .pb_lat(pt_lat[1]),
        .pp_lon(pt_lon[2]), .pp_lat(pt_lat[2]),
        .margin(emarg_reg), .hit(hit_ext)
    );

    soi_box #(.CW(CW)) u_box_abc (
        .aclk(aclk), .ctl(ctl),
        .pa_lon(pt_lon[0]), .pa_lat(pt_lat[0]),
        .pb_lon(pt_lon[1]), .pb_lat(pt_lat[1]),
        .pp_lon(pt_lon[2]), .pp_lat(pt_lat[2]),
        .margin(tmarg_reg), .hit(hit_c)
    );

    soi_box #(.CW(CW)) u_box_abd (
        .aclk(aclk), .ctl(ctl),
        .pa_lon(pt_lon[0]), .pa_lat(pt_lat[0]),
        .pb_lon(pt_lon[1]), .pb_lat(pt_lat[1]),
        .pp_lon(pt_lon[3]), .pp_lat(pt_lat[3]),
        .margin(tmarg_reg), .hit(hit_d)
    );

    soi_box #(.CW(CW)) u_box_cda (
        .aclk(aclk), .ctl(ctl),
        .pa_lon(pt_lon[2]), .pa_lat(pt_lat[2]),
        .pb_lon(pt_lon[3]), .pb_lat(pt_lat[3]),
        .pp_lon(pt_lon[0]), .pp_lat(pt_lat[0]),
        .margin(tmarg_reg), .hit(hit_a)
    );

    soi_box #(.CW(CW)) u_box_cdb (
        .aclk(aclk), .ctl(ctl),
        .pa_lon(pt_lon[2]), .pa_lat(pt_lat[2]),
        .pb_lon(pt_lon[3]), .pb_lat(pt_lat[3]),
        .pp_lon(pt_lon[1]), .pp_lat(pt_lat[1]),
        .margin(tmarg_reg), .hit(hit_b)
    );

    // verdict
    always_comb begin
        differ = (o1 != o2) && (o3 != o4);
        touch  = ((o1 == SIDE_ZERO) && hit_c) || ((o2 == SIDE_ZERO) && hit_d) ||
                 ((o3 == SIDE_ZERO) && hit_a) || ((o4 == SIDE_ZERO) && hit_b);
        case (func4_reg)
            FUNC_ORIENT:    verdict_next = 1'b0;
            FUNC_ON_SEG:    verdict_next = near1 && hit_ext;
            FUNC_INTERSECT: verdict_next = differ || touch;
            FUNC_CROSS:     verdict_next = differ &&
                                (o1 != SIDE_ZERO) && (o2 != SIDE_ZERO) &&
                                (o3 != SIDE_ZERO) && (o4 != SIDE_ZERO);
            default:        verdict_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy[NSTG-1]) begin
            res_reg <= {o1, verdict_next};
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {{(OUT_W-3){1'b0}}, res_reg};

endmodule

@@ sv/soi_checker.sv @@
// ----------------------------------------------------------------------------
// soi_checker
// port level checks of the segment orientation / intersection block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module soi_checker import soi_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    // stalled result word holds
    `ASSERT_CLK_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // side is never the unused code
    `ASSERT_CLK_RST(a_side_code, aclk, aresetn, m_tvalid |-> (m_tdata[2:1] != 2'b10))

    // reset empties the pipeline
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // a free output side never blocks the input
    `ASSERT_CLK(a_no_block, aclk, m_tready |-> s_tready)

endmodule

bind segment_orientation_intersect soi_checker u_soi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/segment_result_checker.sv @@
// ----------------------------------------------------------------------------
// segment_result_checker
// watches the query, result and register ports of the segment predicate block,
// works out the verdict and side of every accepted query word and compares
// each result word field by field against the oldest outstanding prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_result_checker import soi_pkg::*; #(
    parameter int CW   = COORD_WIDTH_DEF,
    parameter int IN_W = ((8 * CW - 4 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_W-1:0]      m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    outstanding
);

    localparam int PT_W = 2 * CW - 1;

    typedef struct packed {
        logic       verdict;
        logic [1:0] side;
    } result_t;

    logic [CFG_DATA_W-1:0] orient_tol;
    logic [CFG_DATA_W-1:0] coll_tol;
    logic [MARGIN_W-1:0]   ext_margin;
    logic [MARGIN_W-1:0]   tch_margin;

    result_t verdicts_due[$];
    result_t want;

    function automatic logic [1:0] side_of(
        input logic signed [63:0] ax, ay, bx, by, cx, cy,
        input logic [CFG_DATA_W-1:0] tol
    );
        logic signed [127:0] xprod;
        logic signed [127:0] lim;
        xprod = 128'(bx - ax) * 128'(cy - ay) - 128'(by - ay) * 128'(cx - ax);
        lim   = $signed({96'd0, tol});
        if (xprod > lim)
            return SIDE_LEFT;
        else if (xprod < -lim)
            return SIDE_RIGHT;
        return SIDE_ZERO;
    endfunction

    function automatic logic in_box(
        input logic signed [63:0] ax, ay, bx, by, px, py,
        input logic [MARGIN_W-1:0] margin
    );
        logic signed [63:0] m;
        logic signed [63:0] lo_x, hi_x, lo_y, hi_y;
        m    = $signed({48'd0, margin});
        lo_x = (ax < bx) ? ax : bx;
        hi_x = (ax < bx) ? bx : ax;
        lo_y = (ay < by) ? ay : by;
        hi_y = (ay < by) ? by : ay;
        return (lo_x - m <= px) && (px <= hi_x + m) &&
               (lo_y - m <= py) && (py <= hi_y + m);
    endfunction

    function automatic result_t segment_verdict(
        input logic [IN_W-1:0]   word,
        input logic [FUNC_W-1:0] func
    );
        logic signed [63:0] px[4];
        logic signed [63:0] py[4];
        logic [1:0] o1, o2, o3, o4;
        result_t r;
        int i;
        for (i = 0; i < 4; i++) begin
            px[i] = 64'($signed(word[i * PT_W +: CW]));
            py[i] = 64'($signed(word[i * PT_W + CW +: CW - 1]));
        end
        o1 = side_of(px[0], py[0], px[1], py[1], px[2], py[2], orient_tol);
        o2 = side_of(px[0], py[0], px[1], py[1], px[3], py[3], orient_tol);
        o3 = side_of(px[2], py[2], px[3], py[3], px[0], py[0], orient_tol);
        o4 = side_of(px[2], py[2], px[3], py[3], px[1], py[1], orient_tol);
        r.side    = o1;
        r.verdict = 1'b0;
        case (func)
            FUNC_ON_SEG: begin
                r.verdict = (side_of(px[0], py[0], px[1], py[1], px[2], py[2], coll_tol)
                             == SIDE_ZERO) &&
                            in_box(px[0], py[0], px[1], py[1], px[2], py[2], ext_margin);
            end
            FUNC_INTERSECT: begin
                if (o1 != o2 && o3 != o4)
                    r.verdict = 1'b1;
                else
                    r.verdict =
                        (o1 == SIDE_ZERO &&
                         in_box(px[0], py[0], px[1], py[1], px[2], py[2], tch_margin)) ||
                        (o2 == SIDE_ZERO &&
                         in_box(px[0], py[0], px[1], py[1], px[3], py[3], tch_margin)) ||
                        (o3 == SIDE_ZERO &&
                         in_box(px[2], py[2], px[3], py[3], px[0], py[0], tch_margin)) ||
                        (o4 == SIDE_ZERO &&
                         in_box(px[2], py[2], px[3], py[3], px[1], py[1], tch_margin));
            end
            FUNC_CROSS: begin
                if (o1 != SIDE_ZERO && o2 != SIDE_ZERO && o3 != SIDE_ZERO && o4 != SIDE_ZERO)
                    r.verdict = (o1 != o2) && (o3 != o4);
            end
            default: r.verdict = 1'b0;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            orient_tol = ORIENT_TOL_RST;
            coll_tol   = COLL_TOL_RST;
            ext_margin = EXT_MARGIN_RST;
            tch_margin = TCH_MARGIN_RST;
            verdicts_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result word with no query outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_tdata[0] !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[2:1] !== want.side) begin
                        $error("side: expected %0d, got %0d",
                               $signed(want.side), $signed(m_tdata[2:1]));
                        fail_count++;
                    end
                    if (m_tdata[OUT_W-1:3] !== '0) begin
                        $error("pad: expected 0, got %h", m_tdata[OUT_W-1:3]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                verdicts_due.push_back(segment_verdict(s_tdata, s_tuser));
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ORIENT_TOL: orient_tol = cfg_wdata;
                    REG_COLL_TOL:   coll_tol   = cfg_wdata;
                    REG_EXT_MARGIN: ext_margin = cfg_wdata[MARGIN_W-1:0];
                    REG_TCH_MARGIN: tch_margin = cfg_wdata[MARGIN_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = verdicts_due.size();
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// regression for segment_orientation_intersect: a directed set of extreme and
// degenerate segment queries, then random queries in phases that each load
// a new register setting and a new pattern of sender gaps and receiver stalls,
// one of them with a long receiver hold-off; the checker judges every word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import soi_pkg::*;;

    localparam int CW         = COORD_WIDTH_DEF;
    localparam int IN_W       = ((8 * CW - 4 + 7) / 8) * 8;
    localparam int PT_W       = 2 * CW - 1;
    localparam int PER_PHASE  = 100;
    localparam int HOLD_LEN   = 300;
    localparam int LIMIT      = 200000;
    localparam int LON_MAX    = 32'sh7fff_ffff;
    localparam int LON_MIN    = 32'sh8000_0000;
    localparam int LAT_MAX    = 32'sh3fff_ffff;
    localparam int LAT_MIN    = -32'sh4000_0000;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [3:0][CW-1:0]   lon;
        logic [3:0][CW-2:0]   lat;
    } query_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int send_idle;
    int recv_stall;
    int hold_count;
    bit hold_req;
    bit hold_done;

    segment_orientation_intersect #(.COORD_WIDTH(CW)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    segment_result_checker #(.CW(CW), .IN_W(IN_W)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("segment_orientation_intersect regression: fail");
        $finish;
    end

    // receiver side, with an optional long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_LEN; hold_count++)
                    @(posedge aclk);
                hold_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic int rand_in(input int unsigned span);
        return int'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic query_t make_query(
        input logic [FUNC_W-1:0] func,
        input int ax, ay, bx, by, cx, cy, dx, dy
    );
        query_t q;
        q.func   = func;
        q.lon[0] = ax;
        q.lat[0] = 31'(ay);
        q.lon[1] = bx;
        q.lat[1] = 31'(by);
        q.lon[2] = cx;
        q.lat[2] = 31'(cy);
        q.lon[3] = dx;
        q.lat[3] = 31'(dy);
        return q;
    endfunction

    function automatic query_t random_query();
        query_t q;
        int unsigned span;
        int base_x, base_y, ux, uy, k, i, src, dst;
        q.func = FUNC_W'($urandom_range(3));
        case ($urandom_range(2))
            0:       span = 6;
            1:       span = 1000;
            default: span = 70000;
        endcase
        base_x = rand_in(1700000000);
        base_y = rand_in(850000000);
        case ($urandom_range(9))
            0: begin
                for (i = 0; i < 4; i++) begin
                    q.lon[i] = $urandom;
                    q.lat[i] = 31'($urandom);
                end
            end
            1: begin
                for (i = 0; i < 4; i++) begin
                    q.lon[i] = rand_in(1800000000);
                    q.lat[i] = 31'(rand_in(900000000));
                end
            end
            2, 3, 4: begin
                // a, b and c near one line through a, with b at twice the step; d on it or at random
                ux = rand_in(span);
                uy = rand_in(span);
                k  = int'($urandom_range(4)) - 1;
                q.lon[0] = base_x;
                q.lat[0] = 31'(base_y);
                q.lon[1] = base_x + 2 * ux;
                q.lat[1] = 31'(base_y + 2 * uy);
                q.lon[2] = base_x + k * ux + (($urandom_range(2) == 0) ? rand_in(1) : 0);
                q.lat[2] = 31'(base_y + k * uy + (($urandom_range(2) == 0) ? rand_in(1) : 0));
                if ($urandom_range(1) == 0) begin
                    k = int'($urandom_range(6)) - 2;
                    q.lon[3] = base_x + k * ux;
                    q.lat[3] = 31'(base_y + k * uy);
                end else begin
                    q.lon[3] = base_x + rand_in(span);
                    q.lat[3] = 31'(base_y + rand_in(span));
                end
            end
            5: begin
                for (i = 0; i < 4; i++) begin
                    q.lon[i] = base_x + rand_in(span);
                    q.lat[i] = 31'(base_y + rand_in(span));
                end
                src = $urandom_range(1);
                dst = 2 + $urandom_range(1);
                q.lon[dst] = q.lon[src];
                q.lat[dst] = q.lat[src];
            end
            default: begin
                for (i = 0; i < 4; i++) begin
                    q.lon[i] = base_x + rand_in(span);
                    q.lat[i] = 31'(base_y + rand_in(span));
                end
            end
        endcase
        return q;
    endfunction

    task automatic send_query(input query_t q);
        logic [IN_W-1:0] word;
        int i;
        word = '0;
        for (i = 0; i < 4; i++) begin
            word[i * PT_W +: CW]          = q.lon[i];
            word[i * PT_W + CW +: CW - 1] = q.lat[i];
        end
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= q.func;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] o_tol, c_tol, e_mgn, t_mgn);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ORIENT_TOL;
        cfg_wdata <= o_tol;
        @(posedge aclk);
        cfg_index <= REG_COLL_TOL;
        cfg_wdata <= c_tol;
        @(posedge aclk);
        cfg_index <= REG_EXT_MARGIN;
        cfg_wdata <= e_mgn;
        @(posedge aclk);
        cfg_index <= REG_TCH_MARGIN;
        cfg_wdata <= t_mgn;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int ph;
        send_idle  = 0;
        recv_stall = 0;
        hold_req   = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words at reset register values
        send_query(make_query(FUNC_ORIENT, 0, 0, 10, 0, 5, 3, 0, 0));
        send_query(make_query(FUNC_ORIENT, 0, 0, 10, 0, 5, -3, 0, 0));
        send_query(make_query(FUNC_ORIENT, 0, 0, 10, 0, 20, 0, 0, 0));
        send_query(make_query(FUNC_ORIENT, LON_MIN, LAT_MIN, LON_MAX, LAT_MAX,
                              LON_MIN, LAT_MAX, LON_MAX, LAT_MIN));
        send_query(make_query(FUNC_ORIENT, LON_MAX, LAT_MIN, LON_MIN, LAT_MAX,
                              LON_MIN, LAT_MIN, LON_MAX, LAT_MAX));
        send_query(make_query(FUNC_ON_SEG, 0, 0, 10, 10, 5, 5, 0, 0));
        send_query(make_query(FUNC_ON_SEG, 0, 0, 10, 10, 15, 15, 0, 0));
        send_query(make_query(FUNC_ON_SEG, 0, 0, 10, 10, 5, 6, 0, 0));
        send_query(make_query(FUNC_ON_SEG, 0, 0, 10, 10, 5, 500, 0, 0));
        send_query(make_query(FUNC_ON_SEG, 7, -7, 7, -7, 7, -7, 0, 0));
        send_query(make_query(FUNC_ON_SEG, LON_MIN, LAT_MIN, LON_MAX, LAT_MAX,
                              LON_MAX, LAT_MAX, 0, 0));
        send_query(make_query(FUNC_INTERSECT, 0, 0, 10, 10, 0, 10, 10, 0));
        send_query(make_query(FUNC_INTERSECT, 0, 0, 10, 0, 10, 0, 10, 5));
        send_query(make_query(FUNC_INTERSECT, 0, 0, 10, 0, 5, 0, 5, 5));
        send_query(make_query(FUNC_INTERSECT, 0, 0, 10, 0, 5, 0, 15, 0));
        send_query(make_query(FUNC_INTERSECT, 0, 0, 10, 0, 20, 0, 30, 0));
        send_query(make_query(FUNC_INTERSECT, 0, 0, 10, 0, 0, 1, 10, 1));
        send_query(make_query(FUNC_INTERSECT, LON_MIN, LAT_MIN, LON_MAX, LAT_MAX,
                              LON_MIN, LAT_MAX, LON_MAX, LAT_MIN));
        send_query(make_query(FUNC_CROSS, 0, 0, 10, 10, 0, 10, 10, 0));
        send_query(make_query(FUNC_CROSS, 0, 0, 10, 0, 5, 0, 5, 5));
        send_query(make_query(FUNC_CROSS, 0, 0, 10, 0, 10, 0, 10, 5));
        send_query(make_query(FUNC_CROSS, LON_MIN, LAT_MIN, LON_MAX, LAT_MAX,
                              LON_MIN, LAT_MAX, LON_MAX, LAT_MIN));
        s_tvalid <= 1'b0;

        for (ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin
                    load_config(32'd0, 32'd0, 32'd0, 32'd0);
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1: begin
                    load_config(32'd3, 32'd40, 32'd2, 32'd3);
                    send_idle  = 60;
                    recv_stall = 0;
                end
                2: begin
                    load_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
                    send_idle  = 0;
                    recv_stall = 60;
                end
                3: begin
                    load_config(32'd1, 32'd1000, 32'd1, 32'd1);
                    send_idle  = 18;
                    recv_stall = 18;
                end
                default: begin
                    load_config(32'd25, 32'd0, 32'h5a5a_0005, 32'h0000_ffff);
                    send_idle  = 0;
                    recv_stall = 0;
                    hold_req   = 1'b1;
                end
            endcase
            repeat (PER_PHASE) send_query(random_query());
            s_tvalid <= 1'b0;
        end

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("segment_orientation_intersect regression: pass");
        else
            $display("segment_orientation_intersect regression: fail");
        $finish;
    end

endmodule
